/* hw/rtl/mhash_pkg.sv */
`timescale 1ns / 1ps

package mhash_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  // Status from the shared multiplier to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

/* hw/rtl/mhash_mul.sv */
`timescale 1ns / 1ps

// Low 64 bits of operand * MIX_MUL, built from three 32x32 partial products
// on one shared multiplier.
module mhash_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         operand,
  output logic [63:0]         product,
  output mhash_pkg::mul_stat_t stat
);

  localparam logic [31:0] MulLo = mhash_pkg::MIX_MUL[31:0];
  localparam logic [31:0] MulHi = mhash_pkg::MIX_MUL[63:32];

  logic [63:0] a_r;
  logic [63:0] acc_r;
  logic [63:0] pp_r;
  logic [1:0]  phase_r;
  logic        busy_r;
  logic        done_r;

  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] pp;

  // Select the partial product for this phase
  always_comb begin
    mx = (phase_r == 2'd2) ? a_r[63:32] : a_r[31:0];
    my = (phase_r == 2'd1) ? MulHi : MulLo;
    pp = {32'b0, mx} * {32'b0, my};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 2'd0;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= operand;
    end else if (busy_r) begin
      pp_r <= pp;
      case (phase_r)
        2'd1:    acc_r <= pp_r;
        2'd2:    acc_r <= acc_r + {pp_r[31:0], 32'b0};
        2'd3:    acc_r <= acc_r + {pp_r[31:0], 32'b0};
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* hw/rtl/murmur_hash_64a.sv */
`timescale 1ns / 1ps

// Streaming MurmurHash64A.
// Input channel (in_*): one item per 64-bit little-endian key word. The first
// item of a key (in_first_word) also brings the seed and declared length;
// the item with in_last_word closes the key. in_byte_count gives the valid
// bytes of the word; counts above eight count as eight, a count of one to seven
// mixes the word as a tail, and a count of zero mixes nothing.
// Result channel (out_*): one item per key, the finished hash and a flag
// that is set when the bytes received differ from the declared length.
// Every 64-bit multiply by the mixing constant runs on one shared 32x32
// multiplier, and the sequencer issues them one after another. in_stall rises
// in the cycle after an item is taken and stays high until the item's work ends.
// The result sits in an output register; a stalled receiver holds it and the
// next key is taken meanwhile; only its finish waits for the register to free.
// Reset (rst_n low, synchronous) clears the running hash, byte count and
// declared length and drops any pending result.
module murmur_hash_64a (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first_word,
  input  logic [63:0] in_seed_value,
  input  logic [31:0] in_key_length,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value,
  output logic        out_length_mismatch
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,  // wait for an item
    S_INIT = 8'b0000_0010,  // length * M for the initial hash
    S_DATA = 8'b0000_0100,  // pick full-word, tail or no mixing
    S_K1   = 8'b0000_1000,  // first multiply of the word
    S_K2   = 8'b0001_0000,  // second multiply of the word
    S_HM   = 8'b0010_0000,  // multiply of the hash
    S_LAST = 8'b0100_0000,  // end of item, start finalization if last
    S_FIN  = 8'b1000_0000   // finalization multiply, then load result
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic [63:0] word_r, word_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [31:0] bytes_r, bytes_nxt;
  logic [31:0] decl_r, decl_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;
  logic        out_mis_r, out_mis_nxt;

  logic                 mul_start;
  logic [63:0]          mul_op;
  logic [63:0]          mul_prod;
  mhash_pkg::mul_stat_t mul_stat;

  logic [63:0] tail_mask;
  logic [32:0] bytes_sum;
  logic [63:0] tail_hash;

  mhash_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (mul_op),
    .product (mul_prod),
    .stat    (mul_stat)
  );

  // Keep only the valid bytes of the tail word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_mask[i*8 +: 8] = (4'(i) < cnt_r) ? 8'hff : 8'h00;
    end
  end

  assign bytes_sum = {1'b0, bytes_r} + {29'b0, cnt_r};
  assign tail_hash = hash_r ^ (word_r & tail_mask);

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    hash_nxt      = hash_r;
    bytes_nxt     = bytes_r;
    decl_nxt      = decl_r;
    out_hash_nxt  = out_hash_r;
    out_mis_nxt   = out_mis_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_start     = 1'b0;
    mul_op        = hash_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          seed_nxt = in_seed_value;
          word_nxt = in_data_word;
          cnt_nxt  = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
          last_nxt = in_last_word;
          if (in_first_word) begin
            decl_nxt  = in_key_length;
            bytes_nxt = 32'd0;
            mul_start = 1'b1;
            mul_op    = {32'b0, in_key_length};
            state_nxt = S_INIT;
          end else begin
            state_nxt = S_DATA;
          end
        end
      end
      S_INIT: begin
        if (mul_stat.done) begin
          hash_nxt  = seed_r ^ mul_prod;
          state_nxt = S_DATA;
        end
      end
      S_DATA: begin
        // Saturate the byte total
        bytes_nxt = bytes_sum[32] ? 32'hffff_ffff : bytes_sum[31:0];
        if (cnt_r == 4'd8) begin
          mul_start = 1'b1;
          mul_op    = word_r;
          state_nxt = S_K1;
        end else if (cnt_r != 4'd0) begin
          mul_start = 1'b1;
          mul_op    = tail_hash;
          state_nxt = S_HM;
        end else begin
          state_nxt = S_LAST;
        end
      end
      S_K1: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_op    = mul_prod ^ (mul_prod >> mhash_pkg::MIX_SHIFT);
          state_nxt = S_K2;
        end
      end
      S_K2: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_op    = hash_r ^ mul_prod;
          state_nxt = S_HM;
        end
      end
      S_HM: begin
        if (mul_stat.done) begin
          hash_nxt  = mul_prod;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (last_r) begin
          mul_start = 1'b1;
          mul_op    = hash_r ^ (hash_r >> mhash_pkg::MIX_SHIFT);
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        // Wait for the product and hold it until the output register is free
        if (!mul_stat.busy && !(out_valid_r && out_stall)) begin
          out_hash_nxt  = mul_prod ^ (mul_prod >> mhash_pkg::MIX_SHIFT);
          out_mis_nxt   = (bytes_r != decl_r);
          out_valid_nxt = 1'b1;
          hash_nxt      = 64'd0;
          bytes_nxt     = 32'd0;
          decl_nxt      = 32'd0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hash_r      <= 64'd0;
      bytes_r     <= 32'd0;
      decl_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      bytes_r     <= bytes_nxt;
      decl_r      <= decl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_r     <= seed_nxt;
    word_r     <= word_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
    out_mis_r  <= out_mis_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_hash_value      = out_hash_r;
  assign out_length_mismatch = out_mis_r;

  // Never restart the multiplier while a product is in flight
  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  // A done pulse closes a busy run
  a_mul_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> $past(mul_stat.busy))
    else $error("multiplier done without a run");

  // A result appears only from the finalization step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside finalization");

  // A first item takes its declared length
  a_first_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_first_word) |=> decl_r == $past(in_key_length))
    else $error("declared length not taken");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for the streaming MurmurHash64A unit.
// Keys go in as sequences of 64-bit words over the in_* channel. Every
// accepted item is folded into a local copy of the hash state, and each
// item that closes a key pushes the expected digest and length flag onto a
// queue. A free-running checker pops that queue for every result accepted
// on the out_* channel and compares the fields. Both channels idle in random
// bursts, except in the closing random phase.
module testbench;

  localparam logic [63:0] MUL_K      = 64'hc6a4a7935bd1e995;
  localparam int          SHIFT_R    = 47;
  localparam int          QUIET_MAX  = 2000;  // cycles without any handshake
  localparam int          DRAIN_WAIT = 40;    // longest item plus margin

  typedef struct packed {
    logic [63:0] hash;
    logic        mismatch;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_first_word = 1'b0;
  logic [63:0] in_seed_value = '0;
  logic [31:0] in_key_length = '0;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_byte_count = '0;
  logic        in_last_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_hash_value;
  logic        out_length_mismatch;

  // Local copy of the hash state, advanced on every accepted item
  logic [63:0] acc_hash = '0;
  logic [31:0] acc_bytes = '0;
  logic [31:0] acc_declared = '0;

  digest_t pending_digests[$];
  int      error_count = 0;
  int      quiet_cycles = 0;
  int      stall_left = 0;
  bit      idle_on = 1'b1;

  murmur_hash_64a dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_first_word       (in_first_word),
    .in_seed_value       (in_seed_value),
    .in_key_length       (in_key_length),
    .in_data_word        (in_data_word),
    .in_byte_count       (in_byte_count),
    .in_last_word        (in_last_word),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hash_value      (out_hash_value),
    .out_length_mismatch (out_length_mismatch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Fold one accepted word into the running hash; on the closing word,
  // finalize, queue the digest and clear the state for the next key.
  function automatic void fold_word(bit first, logic [63:0] seed, logic [31:0] len,
                                    logic [63:0] word, logic [3:0] count, bit last);
    logic [63:0] k;
    logic [63:0] fin;
    logic [31:0] n;
    logic [32:0] total;
    digest_t     d;
    if (first) begin
      acc_hash     = seed ^ ({32'h0, len} * MUL_K);
      acc_bytes    = '0;
      acc_declared = len;
    end
    // Counts above eight act as a full word
    n = (count > 4'd8) ? 32'd8 : {28'h0, count};
    if (n == 32'd8) begin
      k = word * MUL_K;
      k = k ^ (k >> SHIFT_R);
      k = k * MUL_K;
      acc_hash = (acc_hash ^ k) * MUL_K;
    end else if (n != 32'd0) begin
      // Tail rule: mask off the bytes beyond the count, then one multiply
      acc_hash = (acc_hash ^ (word & ((64'h1 << (n * 8)) - 64'h1))) * MUL_K;
    end
    // Byte total saturates instead of wrapping
    total = {1'b0, acc_bytes} + {1'b0, n};
    acc_bytes = total[32] ? 32'hffff_ffff : total[31:0];
    if (last) begin
      fin = acc_hash ^ (acc_hash >> SHIFT_R);
      fin = fin * MUL_K;
      fin = fin ^ (fin >> SHIFT_R);
      d.hash     = fin;
      d.mismatch = (acc_bytes != acc_declared);
      pending_digests.push_back(d);
      acc_hash     = '0;
      acc_bytes    = '0;
      acc_declared = '0;
    end
  endfunction

  // Drive one item and hold it until the block takes it. An optional idle
  // burst comes first; valid is never dropped between back-to-back items.
  task automatic send_word(bit first, logic [63:0] seed, logic [31:0] len,
                           logic [63:0] word, logic [3:0] count, bit last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_first_word <= first;
    in_seed_value <= seed;
    in_key_length <= len;
    in_data_word  <= word;
    in_byte_count <= count;
    in_last_word  <= last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    fold_word(first, seed, len, word, count, last);
  endtask

  // Words before any first item continue from the cleared state
  task automatic test_headless_key();
    send_word(1'b0, rand64(), $urandom, rand64(), 4'd8, 1'b0);
    send_word(1'b0, rand64(), $urandom, rand64(), 4'd3, 1'b1);
  endtask

  // Zero-byte keys: finalization only, with matching and wrong lengths
  task automatic test_empty_keys();
    send_word(1'b1, rand64(), 32'd0, rand64(), 4'd0, 1'b1);
    send_word(1'b1, rand64(), 32'd5, rand64(), 4'd0, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_word(1'b1, '1, '1, '1, 4'd8, 1'b1);
    send_word(1'b1, '0, '0, '0, 4'd8, 1'b0);
    send_word(1'b0, '0, '0, '1, 4'd15, 1'b1);
  endtask

  // Counts one to seven, the first six mid-key and seven closing; upper bytes are all ones
  // so any leak past the mask shows up
  task automatic test_tail_lengths();
    send_word(1'b1, rand64(), 32'd36, rand64(), 4'd8, 1'b0);
    for (int c = 1; c <= 7; c++) begin
      send_word(1'b0, rand64(), $urandom, '1, 4'(c), c == 7);
    end
  endtask

  task automatic test_oversize_counts();
    send_word(1'b1, rand64(), 32'd24, rand64(), 4'd9, 1'b0);
    send_word(1'b0, rand64(), $urandom, rand64(), 4'd12, 1'b0);
    send_word(1'b0, rand64(), $urandom, rand64(), 4'd15, 1'b1);
  endtask

  // A new first item in the middle of a key restarts from its seed
  task automatic test_restart_mid_key();
    send_word(1'b1, rand64(), 32'd8, rand64(), 4'd8, 1'b0);
    send_word(1'b1, rand64(), 32'd8, rand64(), 4'd8, 1'b1);
  endtask

  // Mostly well-formed keys with random content; the rest are stray items,
  // keys left open (the next first restarts them) and wrong lengths.
  task automatic test_random_keys(int n_items, bit with_idle);
    int          sent;
    int          pick;
    int          words;
    int          tail;
    logic [3:0]  count;
    logic [31:0] len;
    sent    = 0;
    idle_on = with_idle;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_word(1'($urandom_range(0, 1)), rand64(), $urandom, rand64(),
                  4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        words = $urandom_range(1, 6);
        tail  = $urandom_range(0, 8);
        len   = (pick == 1) ? $urandom : 32'((words - 1) * 8 + tail);
        for (int w = 0; w < words; w++) begin
          if (w == words - 1) begin
            count = 4'(tail);
          end else begin
            count = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
          end
          // pick 2 leaves the key open
          send_word(w == 0, rand64(), len, rand64(), count, (w == words - 1) && (pick != 2));
          sent++;
        end
      end
    end
  endtask

  // Take results, compare against the oldest expectation, and stall the
  // receiver in random bursts while idling is on.
  always @(posedge clk) begin
    digest_t d;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_digests.size() == 0) begin
        $error("unexpected result: hash_value %h length_mismatch %b",
               out_hash_value, out_length_mismatch);
        error_count++;
      end else begin
        d = pending_digests.pop_front();
        if (out_hash_value !== d.hash) begin
          $error("hash_value: expected %h, got %h", d.hash, out_hash_value);
          error_count++;
        end
        if (out_length_mismatch !== d.mismatch) begin
          $error("length_mismatch: expected %b, got %b", d.mismatch, out_length_mismatch);
          error_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Abort when neither channel has moved for too long
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_headless_key();
    test_empty_keys();
    test_field_extremes();
    test_tail_lengths();
    test_oversize_counts();
    test_restart_mid_key();
    test_random_keys(400, 1'b1);
    test_random_keys(100, 1'b0);

    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mhash_pkg.sv
hw/rtl/mhash_mul.sv
hw/rtl/murmur_hash_64a.sv
tb/testbench.sv
